>>> rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fmsm_pkg.sv
// Package for the flow meter safety monitor: payload types, constants, codes.
// No dependencies.
`timescale 1ns / 1ps
package fmsm_pkg;

    localparam int SLOTS      = 6;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ZONE_COUNT = 16;

    localparam logic [31:0] SAMPLE_INTERVAL_MS = 32'd1000;
    localparam logic [31:0] SAMPLE_WINDOW_MS   = 32'd5000;
    localparam logic [9:0]  MS_PER_SEC         = 10'd1000;
    localparam logic [16:0] MS_PER_MIN         = 17'd60000;

    // percent scaling: x / 100 = (x >> 2) / 25, the / 25 by reciprocal multiply
    localparam logic [30:0] RECIP_25    = 31'h51EB_851F;
    localparam int          RECIP_SHIFT = 35;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PPL       = 3'd0,
        REG_LEAK_WIN  = 3'd1,
        REG_LEAK_THR  = 3'd2,
        REG_NOFLOW    = 3'd3,
        REG_DEV_CONF  = 3'd4,
        REG_LOW_PCT   = 3'd5,
        REG_HIGH_PCT  = 3'd6,
        REG_STD_FLOW  = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [31:0] pulse_count;
        logic [7:0]  zone_id;
    } fmsm_in_t;

    typedef struct packed {
        logic        no_flow;
        logic        low_flow_alarm;
        logic        high_flow_alarm;
        logic        leak_alarm;
        logic [31:0] leak_pulses;
        logic [31:0] flow_rate;
        logic [7:0]  active_zone;
    } fmsm_out_t;

endpackage

>>> rtl/flow_meter_safety_monitor_core.sv
// Flow meter safety monitor top level: tick sequencer, sample ring, shared divider.
// Depends on fmsm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One request in, one result out. Idle, begin and unused ticks go from the dispatch
// state straight to the output. A running tick that takes a new sample walks the
// six sample slots one a cycle and then runs one shared 64-bit restoring divider
// (one quotient bit a cycle) up to twice (volume, then rate); deviation thresholds
// (two divisions by 100) use a reciprocal multiply on ticks where the deviation
// check runs. The result is held in an output register; a new request is taken
// once it has gone.
module flow_meter_safety_monitor_core
    import fmsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fmsm_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fmsm_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EST, S_SCAN, S_VOL_DIV, S_VOL_DONE, S_RATE_DIV,
        S_DEV, S_LO_DIV, S_HI_DIV, S_DEV_EVAL, S_OUT
    } state_t;

    // configuration
    logic [15:0] ppl_reg, leak_win_reg, leak_thr_reg, noflow_reg, dev_conf_reg;
    logic [9:0]  low_pct_reg, high_pct_reg;
    logic [23:0] std_flow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppl_reg <= '0; leak_win_reg <= '0; leak_thr_reg <= '0;
            noflow_reg <= '0; dev_conf_reg <= '0; low_pct_reg <= '0;
            high_pct_reg <= '0; std_flow_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PPL:      ppl_reg      <= cfg_data[15:0];
                REG_LEAK_WIN: leak_win_reg <= cfg_data[15:0];
                REG_LEAK_THR: leak_thr_reg <= cfg_data[15:0];
                REG_NOFLOW:   noflow_reg   <= cfg_data[15:0];
                REG_DEV_CONF: dev_conf_reg <= cfg_data[15:0];
                REG_LOW_PCT:  low_pct_reg  <= cfg_data[9:0];
                REG_HIGH_PCT: high_pct_reg <= cfg_data[9:0];
                REG_STD_FLOW: std_flow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state
    state_t       state_reg;
    fmsm_in_t     req_reg;
    fmsm_out_t    res_reg;
    logic [31:0]  s_time_reg  [SLOTS];
    logic [31:0]  s_pulse_reg [SLOTS];
    logic [CNT_W-1:0]  s_count_reg;
    logic [SLOT_W-1:0] s_next_reg;
    logic [31:0]  last_sample_reg, run_enter_reg, last_ptime_reg, last_pval_reg;
    logic [31:0]  flow_est_reg, idle_start_reg, idle_pulses_reg;
    logic [31:0]  low_since_reg, high_since_reg;
    logic         f_obs_reg, f_low_reg, f_high_reg, f_leak_reg;
    logic [7:0]   zone_reg;

    // scan and estimate working registers
    logic [SLOT_W-1:0] scan_idx_reg;
    logic [31:0]  newest_t_reg, newest_p_reg, old_t_reg, old_p_reg;
    logic         found_reg;
    logic [31:0]  elapsed_reg, lo_reg;

    // shared divider: 64-bit dividend, 32-bit divisor, one bit a cycle
    logic [63:0]  dv_quo_reg;
    logic [32:0]  dv_rem_reg;
    logic [31:0]  dv_den_reg;
    logic [6:0]   dv_cnt_reg;
    logic [33:0]  dv_shift;
    logic [33:0]  dv_trial;
    logic         dv_done;

    assign dv_shift = {dv_rem_reg, dv_quo_reg[63]};
    assign dv_trial = dv_shift - {2'b00, dv_den_reg};
    assign dv_done  = (dv_cnt_reg == 7'd0);

    // percent threshold: dv_quo_reg holds standard flow times percent (34 bits)
    logic [62:0]  pct_prod;
    logic [31:0]  pct_quo;

    assign pct_prod = 63'(dv_quo_reg[33:2]) * 63'(RECIP_25);
    assign pct_quo  = 32'(pct_prod[62:RECIP_SHIFT]);

    // small shared combinational terms
    logic [31:0] now_w, p_w;
    logic [31:0] noflow_ms, dev_ms, leak_ms;
    logic [31:0] d_newest, d_pulses;
    logic        quo_hi_nz;
    logic [31:0] quo_sat;
    logic [CNT_W-1:0] n_slots;

    assign now_w     = req_reg.now_ms;
    assign p_w       = req_reg.pulse_count;
    assign noflow_ms = 32'(noflow_reg * MS_PER_SEC);
    assign dev_ms    = 32'(dev_conf_reg * MS_PER_SEC);
    assign leak_ms   = 32'(leak_win_reg * MS_PER_SEC);
    assign d_newest  = newest_t_reg - s_time_reg[scan_idx_reg];
    assign d_pulses  = newest_p_reg - old_p_reg;
    assign quo_hi_nz = |dv_quo_reg[63:32];
    assign quo_sat   = quo_hi_nz ? 32'hFFFF_FFFF : dv_quo_reg[31:0];
    assign n_slots   = s_count_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    logic dev_enable;
    logic [7:0] zone_m1;
    assign zone_m1 = zone_reg - 8'd1;
    assign dev_enable = (ppl_reg != 16'd0) && (dev_conf_reg != 16'd0) && (zone_reg != 8'd0)
                        && (32'(zone_m1) < 32'(ZONE_COUNT)) && (std_flow_reg != 24'd0)
                        && (flow_est_reg != 32'd0);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s_count_reg <= '0; s_next_reg <= '0;
            last_sample_reg <= '0; run_enter_reg <= '0; last_ptime_reg <= '0;
            last_pval_reg <= '0; flow_est_reg <= '0; idle_start_reg <= '0;
            idle_pulses_reg <= '0; low_since_reg <= '0; high_since_reg <= '0;
            f_obs_reg <= 1'b0; f_low_reg <= 1'b0; f_high_reg <= 1'b0; f_leak_reg <= 1'b0;
            zone_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                s_time_reg[i]  <= '0;
                s_pulse_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    res_reg <= '0;
                    res_reg.flow_rate   <= flow_est_reg;
                    res_reg.active_zone <= zone_reg;
                    state_reg <= S_OUT;
                    case (req_reg.operation)
                        OP_IDLE:
                        begin
                            if (leak_win_reg == 16'd0 || leak_thr_reg == 16'd0)
                            begin
                                idle_start_reg <= '0;
                                f_leak_reg <= 1'b0;
                            end
                            else if (idle_start_reg == 32'd0 ||
                                     now_w - idle_start_reg >= leak_ms)
                            begin
                                idle_start_reg  <= now_w;
                                idle_pulses_reg <= p_w;
                                f_leak_reg <= 1'b0;
                            end
                            else if (!f_leak_reg &&
                                     p_w - idle_pulses_reg >= 32'(leak_thr_reg))
                            begin
                                res_reg.leak_alarm  <= 1'b1;
                                res_reg.leak_pulses <= p_w - idle_pulses_reg;
                                f_leak_reg <= 1'b1;
                            end
                        end
                        OP_BEGIN:
                        begin
                            zone_reg <= req_reg.zone_id;
                            res_reg.active_zone <= req_reg.zone_id;
                            res_reg.flow_rate <= '0;
                            run_enter_reg  <= '0;
                            last_ptime_reg <= now_w;
                            last_pval_reg  <= '0;
                            flow_est_reg   <= '0;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                s_time_reg[i]  <= '0;
                                s_pulse_reg[i] <= '0;
                            end
                            s_time_reg[0] <= now_w;
                            s_count_reg <= CNT_W'(1);
                            s_next_reg  <= SLOT_W'(1);
                            last_sample_reg <= now_w;
                            idle_start_reg  <= '0;
                            idle_pulses_reg <= '0;
                            low_since_reg   <= '0;
                            high_since_reg  <= '0;
                            f_obs_reg <= 1'b0; f_low_reg <= 1'b0;
                            f_high_reg <= 1'b0; f_leak_reg <= 1'b0;
                        end
                        OP_RUN:
                        begin
                            // first running tick after begin: restart the ring
                            if (!f_obs_reg)
                            begin
                                f_obs_reg <= 1'b1;
                                run_enter_reg <= now_w;
                                last_ptime_reg <= now_w;
                                last_pval_reg <= p_w;
                                for (int i = 0; i < SLOTS; i++)
                                begin
                                    s_time_reg[i]  <= '0;
                                    s_pulse_reg[i] <= '0;
                                end
                                s_time_reg[0]  <= now_w;
                                s_pulse_reg[0] <= p_w;
                                s_count_reg <= CNT_W'(1);
                                s_next_reg  <= SLOT_W'(1);
                                last_sample_reg <= now_w;
                                // pulse equals stored value: no-flow uses now-now
                                if (noflow_ms != 32'd0 && 32'd0 >= noflow_ms)
                                    res_reg.no_flow <= 1'b1;
                                else
                                begin
                                    // estimate: now <= entered time, so zero
                                    flow_est_reg <= '0;
                                    state_reg <= S_DEV;
                                end
                            end
                            else
                            begin
                                if (p_w != last_pval_reg)
                                begin
                                    last_pval_reg <= p_w;
                                    last_ptime_reg <= now_w;
                                end
                                if (noflow_ms != 32'd0 && p_w == last_pval_reg &&
                                    now_w - last_ptime_reg >= noflow_ms)
                                    res_reg.no_flow <= 1'b1;
                                else
                                    state_reg <= S_EST;
                            end
                        end
                        default: ;
                    endcase
                end

                S_EST:
                begin
                    state_reg <= S_DEV;
                    if (run_enter_reg == 32'd0 || now_w <= run_enter_reg)
                        flow_est_reg <= '0;
                    else if (s_count_reg == '0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            s_time_reg[i]  <= '0;
                            s_pulse_reg[i] <= '0;
                        end
                        s_time_reg[0]  <= now_w;
                        s_pulse_reg[0] <= p_w;
                        s_count_reg <= CNT_W'(1);
                        s_next_reg  <= SLOT_W'(1);
                        last_sample_reg <= now_w;
                    end
                    else if (now_w - last_sample_reg >= SAMPLE_INTERVAL_MS)
                    begin
                        s_time_reg[s_next_reg]  <= now_w;
                        s_pulse_reg[s_next_reg] <= p_w;
                        s_next_reg <= (s_next_reg == SLOT_W'(SLOTS - 1)) ? '0
                                      : s_next_reg + SLOT_W'(1);
                        if (s_count_reg < CNT_W'(SLOTS))
                            s_count_reg <= s_count_reg + CNT_W'(1);
                        last_sample_reg <= now_w;
                        newest_t_reg <= now_w;
                        newest_p_reg <= p_w;
                        old_t_reg    <= now_w;
                        old_p_reg    <= '0;
                        found_reg    <= 1'b0;
                        scan_idx_reg <= '0;
                        // count below two after the add means no estimate
                        if (s_count_reg != '0 && s_count_reg < CNT_W'(SLOTS)
                            && s_count_reg + CNT_W'(1) < CNT_W'(2))
                            state_reg <= S_DEV;
                        else
                            state_reg <= S_SCAN;
                    end
                end

                // one slot per cycle: oldest sample inside the window
                S_SCAN:
                begin
                    if (32'(scan_idx_reg) < 32'(n_slots))
                    begin
                        if (s_time_reg[scan_idx_reg] != 32'd0 &&
                            s_time_reg[scan_idx_reg] <= newest_t_reg &&
                            d_newest <= SAMPLE_WINDOW_MS &&
                            (!found_reg || s_time_reg[scan_idx_reg] < old_t_reg))
                        begin
                            found_reg <= 1'b1;
                            old_t_reg <= s_time_reg[scan_idx_reg];
                            old_p_reg <= s_pulse_reg[scan_idx_reg];
                        end
                    end
                    if (scan_idx_reg == SLOT_W'(SLOTS - 1))
                        state_reg <= S_VOL_DONE;
                    else
                        scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                end

                // set up the volume division, or go to the deviation check when there is none
                S_VOL_DONE:
                begin
                    elapsed_reg <= newest_t_reg - old_t_reg;
                    if (!found_reg || old_t_reg == newest_t_reg)
                        state_reg <= S_DEV;
                    else if (newest_p_reg < old_p_reg)
                    begin
                        flow_est_reg <= '0;
                        state_reg <= S_DEV;
                    end
                    else
                    begin
                        dv_quo_reg <= 64'(d_pulses) * 64'(MS_PER_SEC);
                        dv_rem_reg <= '0;
                        dv_den_reg <= 32'(ppl_reg);
                        dv_cnt_reg <= 7'd64;
                        state_reg  <= S_VOL_DIV;
                    end
                end

                S_VOL_DIV:
                begin
                    if (!dv_done)
                    begin
                        dv_cnt_reg <= dv_cnt_reg - 7'd1;
                        if (!dv_trial[33])
                        begin
                            dv_rem_reg <= dv_trial[32:0];
                            dv_quo_reg <= {dv_quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg <= dv_shift[32:0];
                            dv_quo_reg <= {dv_quo_reg[62:0], 1'b0};
                        end
                    end
                    else
                    begin
                        // zero pulses or zero ppl give zero volume
                        dv_quo_reg <= (d_pulses == 32'd0 || ppl_reg == 16'd0) ? 64'd0
                                      : 64'(quo_sat) * 64'(MS_PER_MIN);
                        dv_rem_reg <= '0;
                        dv_den_reg <= elapsed_reg;
                        dv_cnt_reg <= 7'd64;
                        state_reg  <= S_RATE_DIV;
                    end
                end

                S_RATE_DIV:
                begin
                    if (!dv_done)
                    begin
                        dv_cnt_reg <= dv_cnt_reg - 7'd1;
                        if (!dv_trial[33])
                        begin
                            dv_rem_reg <= dv_trial[32:0];
                            dv_quo_reg <= {dv_quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg <= dv_shift[32:0];
                            dv_quo_reg <= {dv_quo_reg[62:0], 1'b0};
                        end
                    end
                    else
                    begin
                        flow_est_reg <= quo_sat;
                        state_reg <= S_DEV;
                    end
                end

                // deviation check: load the low threshold product when the check is enabled
                S_DEV:
                begin
                    res_reg.flow_rate <= flow_est_reg;
                    if (dev_enable)
                    begin
                        dv_quo_reg <= 64'(std_flow_reg) * 64'(low_pct_reg);
                        state_reg  <= S_LO_DIV;
                    end
                    else
                        state_reg <= S_OUT;
                end

                // low threshold out, high threshold product in
                S_LO_DIV:
                begin
                    lo_reg <= pct_quo;
                    dv_quo_reg <= 64'(std_flow_reg) * 64'(high_pct_reg);
                    state_reg  <= S_HI_DIV;
                end

                S_HI_DIV:
                begin
                    dv_quo_reg <= 64'(pct_quo);
                    state_reg  <= S_DEV_EVAL;
                end

                // low and high persistence; dv_quo_reg holds the high threshold
                S_DEV_EVAL:
                begin
                    state_reg <= S_OUT;
                    if (lo_reg != 32'd0 && flow_est_reg < lo_reg)
                    begin
                        if (low_since_reg == 32'd0)
                            low_since_reg <= now_w;
                        else if (!f_low_reg && now_w - low_since_reg >= dev_ms)
                        begin
                            res_reg.low_flow_alarm <= 1'b1;
                            f_low_reg <= 1'b1;
                        end
                    end
                    else
                        low_since_reg <= '0;
                    if (dv_quo_reg[31:0] != 32'd0 && flow_est_reg > dv_quo_reg[31:0])
                    begin
                        if (high_since_reg == 32'd0)
                            high_since_reg <= now_w;
                        else if (!f_high_reg && now_w - high_since_reg >= dev_ms)
                        begin
                            res_reg.high_flow_alarm <= 1'b1;
                            f_high_reg <= 1'b1;
                        end
                    end
                    else
                        high_since_reg <= '0;
                end

                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready,
                 "input taken while a result is pending")
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, s_count_reg <= CNT_W'(SLOTS),
                 "sample count beyond ring size")
    `ASSERT_IMPL(a_leak_excl, clk, rst_n, out_valid && out_data.leak_alarm,
                 !out_data.no_flow && !out_data.low_flow_alarm,
                 "leak reported with running alarms")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready,
                 "block ready right after taking a request")

endmodule
